// ===== src/csed_pkg.sv =====
// ----------------------------------------------------------------------------
// csed_pkg
// Shared types and constants of the C string escape decoder.
// ----------------------------------------------------------------------------
package csed_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_QUOTE   = 2'd1;
    localparam logic [1:0] KIND_NUL     = 2'd2;
    localparam logic [1:0] KIND_NOQUOTE = 2'd3;

    // Decoder modes.
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_BODY = 3'd1;
    localparam logic [2:0] MODE_ESC  = 3'd2;
    localparam logic [2:0] MODE_OCT  = 3'd3;
    localparam logic [2:0] MODE_HEX  = 3'd4;

    // Reset value of the length limit register.
    localparam logic [15:0] MAX_LENGTH_RESET = 16'd1500;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_8      = 8'h38;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LV     = 8'h76;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] position;
        logic        last;
    } t_result;

    // A result slot written into the output queue.
    typedef struct packed {
        logic    valid;
        t_result res;
    } t_slot;

endpackage

// ===== src/csed_in_if.sv =====
// ----------------------------------------------------------------------------
// csed_in_if
// Character input channel: one source character per transfer.
// ----------------------------------------------------------------------------
interface csed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       start_record;

    modport source (output valid, output char_in, output start_record, input ready);
    modport sink   (input valid, input char_in, input start_record, output ready);
endinterface

// ===== src/csed_out_if.sv =====
// ----------------------------------------------------------------------------
// csed_out_if
// Result output channel: one decoded byte or marker per transfer.
// ----------------------------------------------------------------------------
interface csed_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] position;
    logic        last;

    modport source (output valid, output kind, output data, output position,
                    output last, input ready);
    modport sink   (input valid, input kind, input data, input position,
                    input last, output ready);
endinterface

// ===== src/csed_cfg_if.sv =====
// ----------------------------------------------------------------------------
// csed_cfg_if
// Configuration write channel carrying the length limit.
// ----------------------------------------------------------------------------
interface csed_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/c_string_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// c_string_escape_decoder
// Decodes a stream of characters holding double-quoted C string literals.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Carries                               Transfer
//  i_in     in   char_in, start_record                 valid & ready
//  o_out    out  kind, data, position, last            valid & ready
//  i_cfg    in   data (max_length)                     valid & ready
//
//  One character is taken per cycle while the queue has room. Each
//  character gives zero, one or two results, queued in a four-entry
//  output queue. The input stalls while the queue holds more than two
//  results, so the output drain rate of one result per ready cycle sets
//  the sustained rate. Reset is synchronous and active low; it empties the
//  queue, returns the decoder to idle and sets max_length to 1500. Both
//  input channels hold ready low while reset is asserted.
//
module c_string_escape_decoder #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csed_in_if.sink    i_in,
    csed_cfg_if.sink   i_cfg,
    csed_out_if.source o_out
);
    import csed_pkg::*;

    logic [15:0]            r_max_length;
    logic [2:0]             r_mode;
    logic [8:0]             r_escape_value;
    logic [1:0]             r_digit_count;
    logic [COUNT_WIDTH-1:0] r_byte_count;

    logic [2:0]             n_mode;
    logic [8:0]             n_escape_value;
    logic [1:0]             n_digit_count;
    logic [COUNT_WIDTH-1:0] n_byte_count;
    logic [COUNT_WIDTH-1:0] cur_count;
    t_slot                  slot0;
    t_slot                  slot1;
    logic                   room;
    logic                   take;

    assign i_cfg.ready = i_rst_n;
    assign i_in.ready  = room && i_rst_n;
    assign take        = i_in.valid && i_in.ready;

    // A new record restarts the byte numbering before this character.
    assign cur_count = i_in.start_record ? '0 : r_byte_count;

    csed_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .i_mode         (r_mode),
        .i_escape_value (r_escape_value),
        .i_digit_count  (r_digit_count),
        .i_byte_count   (cur_count),
        .i_max_length   (r_max_length),
        .i_char         (i_in.char_in),
        .o_mode         (n_mode),
        .o_escape_value (n_escape_value),
        .o_digit_count  (n_digit_count),
        .o_byte_count   (n_byte_count),
        .o_slot0        (slot0),
        .o_slot1        (slot1)
    );

    csed_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_slot0 (slot0),
        .i_slot1 (slot1),
        .o_room  (room),
        .o_out   (o_out)
    );

    // Decoder state advances on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_IDLE;
            r_escape_value <= 9'd0;
            r_digit_count  <= 2'd0;
            r_byte_count   <= '0;
        end else if (take) begin
            r_mode         <= n_mode;
            r_escape_value <= n_escape_value;
            r_digit_count  <= n_digit_count;
            r_byte_count   <= n_byte_count;
        end
    end

    // Length limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
        end else if (i_cfg.valid) begin
            r_max_length <= i_cfg.data;
        end
    end

endmodule

// ===== src/csed_decode.sv =====
// ----------------------------------------------------------------------------
// csed_decode
// Combinational step of the decoder: next state and up to two results.
// ----------------------------------------------------------------------------
module csed_decode #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic [2:0]             i_mode,
    input  logic [8:0]             i_escape_value,
    input  logic [1:0]             i_digit_count,
    input  logic [COUNT_WIDTH-1:0] i_byte_count,
    input  logic [15:0]            i_max_length,
    input  logic [7:0]             i_char,
    output logic [2:0]             o_mode,
    output logic [8:0]             o_escape_value,
    output logic [1:0]             o_digit_count,
    output logic [COUNT_WIDTH-1:0] o_byte_count,
    output csed_pkg::t_slot        o_slot0,
    output csed_pkg::t_slot        o_slot1
);
    import csed_pkg::*;

    localparam int CmpW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    // A candidate result before the length limit is applied.
    typedef struct packed {
        logic       valid;
        logic       is_byte;
        logic [1:0] kind;
        logic [7:0] data;
    } t_act;

    function automatic t_act act_push(input logic [1:0] kind);
        t_act a;
        a.valid   = 1'b1;
        a.is_byte = 1'b0;
        a.kind    = kind;
        a.data    = 8'd0;
        return a;
    endfunction

    function automatic t_act act_byte(input logic [7:0] value);
        t_act a;
        a.valid   = 1'b1;
        a.is_byte = 1'b1;
        a.kind    = KIND_BYTE;
        a.data    = value;
        return a;
    endfunction

    // Result of an ordinary character inside the literal.
    function automatic t_act body_act(input logic [7:0] c);
        t_act a;
        a = '0;
        if (c == CH_QUOTE) begin
            a = act_push(KIND_QUOTE);
        end else if (c == CH_NUL) begin
            a = act_push(KIND_NUL);
        end else if (c != CH_BSLASH) begin
            a = act_byte(c);
        end
        return a;
    endfunction

    function automatic logic [2:0] body_mode(input logic [7:0] c);
        logic [2:0] m;
        m = MODE_BODY;
        if (c == CH_QUOTE || c == CH_NUL) begin
            m = MODE_IDLE;
        end else if (c == CH_BSLASH) begin
            m = MODE_ESC;
        end
        return m;
    endfunction

    // Byte for a single-letter escape; other characters stand for themselves.
    function automatic logic [7:0] letter_byte(input logic [7:0] c);
        logic [7:0] b;
        case (c)
            CH_LA:   b = 8'd7;
            CH_LB:   b = 8'd8;
            CH_LF:   b = 8'd12;
            CH_LN:   b = 8'd10;
            CH_LR:   b = 8'd13;
            CH_LT:   b = 8'd9;
            CH_LV:   b = 8'd11;
            default: b = c;
        endcase
        return b;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
               (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CH_0 && c <= CH_9) begin
            v = c - CH_0;
        end else if (c >= CH_LA && c <= CH_LF) begin
            v = c - CH_LA + 8'd10;
        end else if (c >= CH_UA && c <= CH_UF) begin
            v = c - CH_UA + 8'd10;
        end
        return v[3:0];
    endfunction

    function automatic logic has_room(input logic [COUNT_WIDTH-1:0] cnt,
                                      input logic [15:0] limit);
        logic [CmpW-1:0] cnt_x;
        logic [CmpW-1:0] lim_x;
        cnt_x = CmpW'(cnt);
        lim_x = CmpW'(limit);
        return (cnt_x < lim_x) && (cnt != {COUNT_WIDTH{1'b1}});
    endfunction

    t_act                   a0;
    t_act                   a1;
    logic                   is_oct;
    logic [8:0]             oct_acc;
    logic [8:0]             hex_acc;
    logic                   ok0;
    logic                   ok1;
    logic                   inc0;
    logic                   inc1;
    logic [COUNT_WIDTH-1:0] cnt1;
    t_result                r0;
    t_result                r1;

    assign is_oct  = (i_char >= CH_0) && (i_char <= CH_7);
    assign oct_acc = {i_escape_value[5:0], i_char[2:0]};
    assign hex_acc = {i_escape_value[4:0], hex_val(i_char)};

    // Mode handling: candidate results and next escape state.
    always_comb begin
        a0             = '0;
        a1             = '0;
        o_mode         = i_mode;
        o_escape_value = i_escape_value;
        o_digit_count  = i_digit_count;
        case (i_mode)
            MODE_IDLE: begin
                if (i_char == CH_QUOTE) begin
                    o_mode = MODE_BODY;
                end else begin
                    a0 = act_push(KIND_NOQUOTE);
                end
            end
            MODE_BODY: begin
                a0     = body_act(i_char);
                o_mode = body_mode(i_char);
            end
            MODE_ESC: begin
                o_mode = MODE_BODY;
                if (i_char == CH_NUL) begin
                    a0     = act_push(KIND_NUL);
                    o_mode = MODE_IDLE;
                end else if (is_oct) begin
                    o_escape_value = {6'd0, i_char[2:0]};
                    o_digit_count  = 2'd1;
                    o_mode         = MODE_OCT;
                end else if (i_char == CH_8 || i_char == CH_9) begin
                    a0 = act_byte(8'd0);
                    a1 = act_byte(i_char);
                end else if (i_char == CH_LX) begin
                    o_escape_value = 9'd0;
                    o_digit_count  = 2'd0;
                    o_mode         = MODE_HEX;
                end else begin
                    a0 = act_byte(letter_byte(i_char));
                end
            end
            MODE_OCT: begin
                if (is_oct && i_digit_count != 2'd3) begin
                    if (i_digit_count == 2'd2) begin
                        a0             = act_byte(oct_acc[7:0]);
                        o_escape_value = 9'd0;
                        o_digit_count  = 2'd0;
                        o_mode         = MODE_BODY;
                    end else begin
                        o_escape_value = oct_acc;
                        o_digit_count  = i_digit_count + 2'd1;
                    end
                end else begin
                    a0             = act_byte(i_escape_value[7:0]);
                    a1             = body_act(i_char);
                    o_escape_value = 9'd0;
                    o_digit_count  = 2'd0;
                    o_mode         = body_mode(i_char);
                end
            end
            MODE_HEX: begin
                if (is_hex(i_char) && i_digit_count < 2'd2) begin
                    if (i_digit_count == 2'd1) begin
                        a0             = act_byte(hex_acc[7:0]);
                        o_escape_value = 9'd0;
                        o_digit_count  = 2'd0;
                        o_mode         = MODE_BODY;
                    end else begin
                        o_escape_value = hex_acc;
                        o_digit_count  = i_digit_count + 2'd1;
                    end
                end else begin
                    a0             = act_byte(i_escape_value[7:0]);
                    a1             = body_act(i_char);
                    o_escape_value = 9'd0;
                    o_digit_count  = 2'd0;
                    o_mode         = body_mode(i_char);
                end
            end
            default: begin
                o_mode         = MODE_IDLE;
                o_escape_value = 9'd0;
                o_digit_count  = 2'd0;
                a0             = act_push(KIND_NOQUOTE);
            end
        endcase
    end

    // Apply the length limit and number the kept bytes.
    assign ok0  = a0.valid && (!a0.is_byte || has_room(i_byte_count, i_max_length));
    assign inc0 = a0.valid && a0.is_byte && ok0;
    assign cnt1 = i_byte_count + COUNT_WIDTH'(inc0);
    assign ok1  = a1.valid && (!a1.is_byte || has_room(cnt1, i_max_length));
    assign inc1 = a1.valid && a1.is_byte && ok1;
    assign o_byte_count = cnt1 + COUNT_WIDTH'(inc1);

    // Positions carry the low 16 bits of the count, whatever its width.
    always_comb begin
        r0.kind     = a0.kind;
        r0.data     = a0.data;
        r0.position = 16'(i_byte_count);
        r0.last     = !ok1;
        r1.kind     = a1.kind;
        r1.data     = a1.data;
        r1.position = 16'(cnt1);
        r1.last     = 1'b1;
    end

    // Pack the kept results so that the first slot fills first.
    always_comb begin
        o_slot0 = '0;
        o_slot1 = '0;
        if (ok0) begin
            o_slot0.valid = 1'b1;
            o_slot0.res   = r0;
            o_slot1.valid = ok1;
            o_slot1.res   = r1;
        end else if (ok1) begin
            o_slot0.valid = 1'b1;
            o_slot0.res   = r1;
        end
    end

endmodule

// ===== src/csed_outq.sv =====
// ----------------------------------------------------------------------------
// csed_outq
// Four-entry result queue: takes up to two results per cycle, sends one.
// ----------------------------------------------------------------------------
module csed_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  csed_pkg::t_slot     i_slot0,
    input  csed_pkg::t_slot     i_slot1,
    output logic                o_room,
    csed_out_if.source          o_out
);
    import csed_pkg::*;

    localparam int Depth = 4;

    t_result    r_q [Depth];
    t_result    n_q [Depth];
    logic [2:0] r_count;
    logic [2:0] n_count;
    logic [2:0] base;
    logic       pop;
    logic       put0;
    logic       put1;

    // Room for the worst case of two results from one transfer.
    assign o_room = (r_count <= 3'd2);

    assign pop  = o_out.valid && o_out.ready;
    assign put0 = i_push && i_slot0.valid;
    assign put1 = i_push && i_slot1.valid;
    assign base = r_count - 3'(pop);

    // Shift out the head entry and append new results behind the rest.
    always_comb begin
        for (int i = 0; i < Depth; i++) begin
            if (pop && i < Depth - 1) begin
                n_q[i] = r_q[(i + 1) % Depth];
            end else begin
                n_q[i] = r_q[i];
            end
            if (put0 && base == 3'(i)) begin
                n_q[i] = i_slot0.res;
            end
            if (put1 && base + 3'd1 == 3'(i)) begin
                n_q[i] = i_slot1.res;
            end
        end
        n_count = base + 3'(put0) + 3'(put1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_out.valid    = (r_count != 3'd0);
    assign o_out.kind     = r_q[0].kind;
    assign o_out.data     = r_q[0].data;
    assign o_out.position = r_q[0].position;
    assign o_out.last     = r_q[0].last;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the C string escape decoder. A short directed
// table comes first. Randomized literals follow under several length limits
// and flow-control settings. Each result is checked against a typed-in
// expectation or a bench decoder of the escape state and record byte count.
// ----------------------------------------------------------------------------
module tb_top;
    import csed_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 225;
    localparam int NUM_PHASES     = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int DIR_ROWS       = 28;

    // One stimulus row; the result fields hold a typed-in expectation.
    typedef struct packed {
        logic [7:0]  ch;
        logic        st;
        logic        typed;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] pos;
    } t_stim_row;

    localparam logic [7:0] ESC_LETTERS [7] = '{CH_LA, CH_LB, CH_LF, CH_LN, CH_LR, CH_LT, CH_LV};

    // Directed table: idle rejects, extremes, letter, digit, octal and hex escapes,
    // an escape cut short, a NUL after a backslash and a record restart.
    localparam t_stim_row DIRECTED [DIR_ROWS] = '{
        '{CH_UA,     1'b1, 1'b1, KIND_NOQUOTE, 8'h00, 16'd0},
        '{CH_NUL,    1'b0, 1'b1, KIND_NOQUOTE, 8'h00, 16'd0},
        '{8'hFF,     1'b0, 1'b1, KIND_NOQUOTE, 8'h00, 16'd0},
        '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{8'hFF,     1'b0, 1'b1, KIND_BYTE,    8'hFF, 16'd0},
        '{8'h01,     1'b0, 1'b1, KIND_BYTE,    8'h01, 16'd1},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_LA,     1'b0, 1'b1, KIND_BYTE,    8'h07, 16'd2},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_LV,     1'b0, 1'b1, KIND_BYTE,    8'h0B, 16'd3},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_9,      1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_7,      1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_7,      1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_7,      1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_LX,     1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_UF,     1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_LF,     1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_LX,     1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_QUOTE,  1'b1, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_NUL,    1'b0, 1'b1, KIND_NUL,     8'h00, 16'd0},
        '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE,    8'h00, 16'd0},
        '{CH_QUOTE,  1'b0, 1'b1, KIND_QUOTE,   8'h00, 16'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    csed_in_if  in_ch ();
    csed_out_if out_ch ();
    csed_cfg_if cfg_ch ();

    c_string_escape_decoder #(
        .COUNT_WIDTH(16)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    // Decoder state tracked by the bench.
    logic [2:0]  dec_mode   = MODE_IDLE;
    logic [8:0]  esc_acc    = '0;
    logic [1:0]  esc_digits = '0;
    logic [15:0] kept_cnt   = '0;
    logic [15:0] len_limit  = MAX_LENGTH_RESET;

    t_result   step_results [$];
    t_result   pending_results [$];
    t_stim_row stim_q [$];
    int        mon_idx = 0;
    int        err_count = 0;
    int        sender_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_request = 1'b0;
    int        quiet_cycles = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic put_result(input logic [1:0] kind, input logic [7:0] data,
                              input logic [15:0] pos);
        t_result r;
        r.kind     = kind;
        r.data     = data;
        r.position = pos;
        r.last     = 1'b0;
        step_results.push_back(r);
    endtask

    // A byte is kept only while the record has room.
    task automatic put_byte(input logic [7:0] value);
        if (kept_cnt < len_limit && kept_cnt != 16'hFFFF) begin
            put_result(KIND_BYTE, value, kept_cnt);
            kept_cnt++;
        end
    endtask

    task automatic body_step(input logic [7:0] c);
        if (c == CH_QUOTE) begin
            put_result(KIND_QUOTE, 8'h00, kept_cnt);
            dec_mode = MODE_IDLE;
        end else if (c == CH_NUL) begin
            put_result(KIND_NUL, 8'h00, kept_cnt);
            dec_mode = MODE_IDLE;
        end else if (c == CH_BSLASH) begin
            dec_mode = MODE_ESC;
        end else begin
            put_byte(c);
            dec_mode = MODE_BODY;
        end
    endtask

    // Works out the results of one accepted character into step_results.
    task automatic decode_char(input logic [7:0] c, input logic st);
        logic [7:0] b;
        logic [3:0] nib;
        logic       hex_ok;
        step_results.delete();
        if (st) begin
            kept_cnt = '0;
        end
        case (dec_mode)
            MODE_IDLE: begin
                if (c == CH_QUOTE) begin
                    dec_mode = MODE_BODY;
                end else begin
                    put_result(KIND_NOQUOTE, 8'h00, kept_cnt);
                end
            end
            MODE_BODY: begin
                body_step(c);
            end
            MODE_ESC: begin
                dec_mode = MODE_BODY;
                if (c == CH_NUL) begin
                    put_result(KIND_NUL, 8'h00, kept_cnt);
                    dec_mode = MODE_IDLE;
                end else if (c >= CH_0 && c <= CH_7) begin
                    esc_acc    = 9'(c - CH_0);
                    esc_digits = 2'd1;
                    dec_mode   = MODE_OCT;
                end else if (c == CH_8 || c == CH_9) begin
                    put_byte(8'h00);
                    put_byte(c);
                end else if (c == CH_LX) begin
                    esc_acc    = '0;
                    esc_digits = '0;
                    dec_mode   = MODE_HEX;
                end else begin
                    case (c)
                        CH_LA:   b = 8'd7;
                        CH_LB:   b = 8'd8;
                        CH_LF:   b = 8'd12;
                        CH_LN:   b = 8'd10;
                        CH_LR:   b = 8'd13;
                        CH_LT:   b = 8'd9;
                        CH_LV:   b = 8'd11;
                        default: b = c;
                    endcase
                    put_byte(b);
                end
            end
            MODE_OCT: begin
                if (c >= CH_0 && c <= CH_7 && esc_digits < 2'd3) begin
                    esc_acc = {esc_acc[5:0], 3'(c - CH_0)};
                    esc_digits++;
                    if (esc_digits >= 2'd3) begin
                        put_byte(esc_acc[7:0]);
                        esc_acc    = '0;
                        esc_digits = '0;
                        dec_mode   = MODE_BODY;
                    end
                end else begin
                    put_byte(esc_acc[7:0]);
                    esc_acc    = '0;
                    esc_digits = '0;
                    body_step(c);
                end
            end
            MODE_HEX: begin
                hex_ok = 1'b1;
                nib    = '0;
                if (c >= CH_0 && c <= CH_9) begin
                    nib = 4'(c - CH_0);
                end else if (c >= CH_LA && c <= CH_LF) begin
                    nib = 4'(c - CH_LA + 8'd10);
                end else if (c >= CH_UA && c <= CH_UF) begin
                    nib = 4'(c - CH_UA + 8'd10);
                end else begin
                    hex_ok = 1'b0;
                end
                if (hex_ok && esc_digits < 2'd2) begin
                    esc_acc = {esc_acc[4:0], nib};
                    esc_digits++;
                    if (esc_digits >= 2'd2) begin
                        put_byte(esc_acc[7:0]);
                        esc_acc    = '0;
                        esc_digits = '0;
                        dec_mode   = MODE_BODY;
                    end
                end else begin
                    put_byte(esc_acc[7:0]);
                    esc_acc    = '0;
                    esc_digits = '0;
                    body_step(c);
                end
            end
            default: begin
                dec_mode   = MODE_IDLE;
                esc_acc    = '0;
                esc_digits = '0;
                put_result(KIND_NOQUOTE, 8'h00, kept_cnt);
            end
        endcase
        if (step_results.size() > 0) begin
            step_results[step_results.size() - 1].last = 1'b1;
        end
    endtask

    task automatic add_item(input logic [7:0] c, input logic st);
        t_stim_row row;
        row       = '0;
        row.ch    = c;
        row.st    = st;
        stim_q.push_back(row);
    endtask

    // One literal with random content; most are closed, some are cut off.
    task automatic add_literal();
        int         pieces;
        int         sel;
        int         n;
        int         r;
        logic [7:0] c;
        add_item(CH_QUOTE, ($urandom_range(0, 2) == 0));
        pieces = $urandom_range(0, 10);
        repeat (pieces) begin
            sel = $urandom_range(0, 9);
            if (sel <= 3) begin
                do begin
                    c = 8'($urandom_range(1, 255));
                end while (c == CH_QUOTE || c == CH_BSLASH);
                add_item(c, 1'b0);
            end else begin
                add_item(CH_BSLASH, 1'b0);
                case (sel)
                    4: add_item(ESC_LETTERS[$urandom_range(0, 6)], 1'b0);
                    5: add_item(8'($urandom_range(0, 255)), 1'b0);
                    6: begin
                        n = $urandom_range(1, 4);
                        repeat (n) add_item(8'(CH_0 + $urandom_range(0, 7)), 1'b0);
                    end
                    7: begin
                        add_item(CH_LX, 1'b0);
                        n = $urandom_range(0, 3);
                        repeat (n) begin
                            r = $urandom_range(0, 21);
                            add_item(8'(r < 10 ? CH_0 + r :
                                        r < 16 ? CH_LA + (r - 10) : CH_UA + (r - 16)), 1'b0);
                        end
                    end
                    8: add_item(($urandom_range(0, 1) == 1) ? CH_9 : CH_8, 1'b0);
                    default: add_item(CH_BSLASH, 1'b0);
                endcase
            end
        end
        // Left open now and then, so the next opening quote closes it instead.
        sel = $urandom_range(0, 19);
        if (sel < 16) begin
            add_item(CH_QUOTE, 1'b0);
        end else if (sel < 19) begin
            add_item(CH_NUL, 1'b0);
        end
    endtask

    // Mostly literals; about one pick in ten adds a single raw noise item.
    task automatic build_random(input int n_items);
        stim_q.delete();
        while (stim_q.size() < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                add_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
            end else begin
                add_literal();
            end
        end
    endtask

    task automatic write_max_length(input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drive_items();
        int idx;
        idx = 0;
        while (idx < stim_q.size()) begin
            if ($urandom_range(0, 99) < sender_idle_pct) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end else begin
                in_ch.valid        <= 1'b1;
                in_ch.char_in      <= stim_q[idx].ch;
                in_ch.start_record <= stim_q[idx].st;
                @(posedge i_clk);
                while (!in_ch.ready) @(posedge i_clk);
                idx++;
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    // Sends the prepared items, then waits for the block to drain and settle.
    task automatic run_phase(input int send_pct, input int stall_pct, input bit hold);
        sender_idle_pct = send_pct;
        recv_stall_pct  = stall_pct;
        mon_idx         = 0;
        if (hold) begin
            hold_request = 1'b1;
        end
        drive_items();
        // One more edge so the checker has queued the last transfer's results.
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Output ready: random stalls, plus a long hold-off on request.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Predicts on every input transfer and checks every output transfer.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                len_limit = cfg_ch.data;
            end
            if (in_ch.valid && in_ch.ready) begin
                decode_char(in_ch.char_in, in_ch.start_record);
                if (mon_idx < stim_q.size() && stim_q[mon_idx].typed) begin
                    want.kind     = stim_q[mon_idx].kind;
                    want.data     = stim_q[mon_idx].data;
                    want.position = stim_q[mon_idx].pos;
                    want.last     = 1'b1;
                    pending_results.push_back(want);
                end else begin
                    foreach (step_results[i]) pending_results.push_back(step_results[i]);
                end
                mon_idx++;
            end
            if (out_ch.valid && out_ch.ready) begin
                got.kind     = out_ch.kind;
                got.data     = out_ch.data;
                got.position = out_ch.position;
                got.last     = out_ch.last;
                if (pending_results.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("%0t unexpected result: kind %0d data %h position %0d last %0d",
                                 $time, got.kind, got.data, got.position, got.last);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            $display("%0t mismatch: expected kind %0d data %h position %0d last %0d",
                                     $time, want.kind, want.data, want.position, want.last);
                            $display("%0t           actual   kind %0d data %h position %0d last %0d",
                                     $time, got.kind, got.data, got.position, got.last);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Main sequence: reset, directed table, then the random phases.
    initial begin
        logic [15:0] limit_val;
        int          send_pct;
        int          stall_pct;
        bit          hold;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.char_in      <= '0;
        in_ch.start_record <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.data        <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset length limit.
        stim_q.delete();
        foreach (DIRECTED[i]) stim_q.push_back(DIRECTED[i]);
        run_phase(0, 0, 1'b0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            hold = 1'b0;
            case (ph)
                0: begin limit_val = 16'hFFFF; send_pct = 0;  stall_pct = 0;  end
                1: begin limit_val = 16'd0;    send_pct = 88; stall_pct = 0;  end
                2: begin limit_val = 16'd1;    send_pct = 0;  stall_pct = 88; end
                3: begin limit_val = 16'($urandom_range(2, 12)); send_pct = 37; stall_pct = 37; end
                4: begin limit_val = 16'd40;   send_pct = 0;  stall_pct = 0;  hold = 1'b1; end
                5: begin limit_val = 16'($urandom_range(0, 65535)); send_pct = 88; stall_pct = 0; end
                6: begin limit_val = 16'($urandom_range(2, 12)); send_pct = 0; stall_pct = 88; end
                default: begin limit_val = 16'hFFFF; send_pct = 37; stall_pct = 37; end
            endcase
            write_max_length(limit_val);
            build_random(PHASE_ITEMS);
            run_phase(send_pct, stall_pct, hold);
        end

        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
